// ===== rtl/cpg_pkg.sv =====
// ----------------------------------------------------------------------------
// CpG site window merger package
// Shared constants and record bundle types for the site scanner and the
// record queue.
// ----------------------------------------------------------------------------
package cpg_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CHROM_W = 8;
  localparam int unsigned KMER_W  = 8;
  localparam int unsigned OUT_W   = 32;

  // Default position counter width.
  localparam int unsigned POS_BITS_DEF = 32;

  // Matched characters and the k-mer length after reset.
  localparam logic [CHAR_W-1:0] CHAR_C     = 8'd67;
  localparam logic [CHAR_W-1:0] CHAR_G     = 8'd71;
  localparam logic [KMER_W-1:0] KMER_RESET = 8'd25;

  // Record kinds on the output.
  localparam logic REC_SITE = 1'b0;
  localparam logic REC_IVL  = 1'b1;

  // Record slots inside one bundle, in output order.
  localparam int unsigned SLOT_SITE  = 0;
  localparam int unsigned SLOT_CLOSE = 1;
  localparam int unsigned SLOT_LAST  = 2;
  localparam int unsigned SLOTS      = 3;

  // One closed interval as it leaves the block.
  typedef struct packed {
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] stop;
    logic [OUT_W-1:0] first;
    logic [OUT_W-1:0] count;
  } ivl_t;

  // All records caused by one input item.
  typedef struct packed {
    logic [CHROM_W-1:0] chrom;
    logic [OUT_W-1:0]   site_pos;
    logic [OUT_W-1:0]   site_idx;
    ivl_t               close_site;
    ivl_t               close_last;
  } bundle_t;

endpackage

// ===== rtl/cpg_site_scan.sv =====
// ----------------------------------------------------------------------------
// CpG site scanner
// Detects C-G pairs, merges site windows into the open interval and builds
// the bundle of records caused by each accepted character.
// ----------------------------------------------------------------------------
module cpg_site_scan #(
  parameter int unsigned PosBits = cpg_pkg::POS_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cpg_pkg::KMER_W-1:0]   kmer_len_i,
  input  logic                         accept_i,
  input  logic [cpg_pkg::CHAR_W-1:0]   seq_char_i,
  input  logic [cpg_pkg::CHROM_W-1:0]  chrom_id_i,
  input  logic                         last_char_i,
  output cpg_pkg::bundle_t             bundle_o,
  output logic [cpg_pkg::SLOTS-1:0]    mask_o
);

  localparam int unsigned OW = cpg_pkg::OUT_W;

  // Scanner state.
  logic               prev_c_q, prev_c_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic               open_q, open_d;
  logic [PosBits:0]   ostart_q, ostart_d;
  logic [PosBits:0]   oend_q, oend_d;
  logic [OW-1:0]      ofirst_q, ofirst_d;
  logic [OW-1:0]      ocount_q, ocount_d;
  logic [OW-1:0]      total_q, total_d;

  // Site and window arithmetic.
  logic               is_site, merge, close_site, close_last;
  logic [PosBits-1:0] cpos;
  logic [PosBits:0]   kmer, site_end, win_start, win_end, seq_len, last_end;

  // State after the site of this character has been merged.
  logic               s1_open;
  logic [PosBits:0]   s1_start, s1_end;
  logic [OW-1:0]      s1_first, s1_count;

  // Zero-extended copies for cutting positions to the output width.
  logic [63:0]        cpos_w, ostart_w, oend_w, s1_start_w, last_end_w;

  always_comb begin
    is_site   = prev_c_q && (seq_char_i == cpg_pkg::CHAR_G);
    cpos      = pos_q - PosBits'(1);
    kmer      = (PosBits + 1)'(kmer_len_i);
    site_end  = {1'b0, cpos} + (PosBits + 1)'(2);
    win_start = (site_end >= kmer) ? site_end - kmer : '0;
    win_end   = {1'b0, cpos} + kmer;
    merge      = is_site && open_q && (oend_q >= site_end);
    close_site = is_site && open_q && !merge;
  end

  // Merge the site window into the open interval or open a new one.
  always_comb begin
    s1_open  = open_q || is_site;
    s1_start = ostart_q;
    s1_end   = oend_q;
    s1_first = ofirst_q;
    s1_count = ocount_q;
    if (merge) begin
      s1_end   = win_end;
      s1_count = ocount_q + OW'(1);
    end else if (is_site) begin
      s1_start = win_start;
      s1_end   = win_end;
      s1_first = total_q;
      s1_count = OW'(1);
    end
  end

  // The final character closes the interval, clamped to the sequence length.
  always_comb begin
    seq_len    = {1'b0, pos_q} + (PosBits + 1)'(1);
    last_end   = (s1_end > seq_len) ? seq_len : s1_end;
    close_last = last_char_i && s1_open;
  end

  // Next state.
  always_comb begin
    ostart_d = s1_start;
    oend_d   = s1_end;
    ofirst_d = s1_first;
    ocount_d = s1_count;
    total_d  = total_q + OW'(is_site);
    if (last_char_i) begin
      open_d   = 1'b0;
      pos_d    = '0;
      prev_c_d = 1'b0;
    end else begin
      open_d   = s1_open;
      pos_d    = pos_q + PosBits'(1);
      prev_c_d = (seq_char_i == cpg_pkg::CHAR_C);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_c_q <= 1'b0;
      pos_q    <= '0;
      open_q   <= 1'b0;
      ostart_q <= '0;
      oend_q   <= '0;
      ofirst_q <= '0;
      ocount_q <= '0;
      total_q  <= '0;
    end else if (accept_i) begin
      prev_c_q <= prev_c_d;
      pos_q    <= pos_d;
      open_q   <= open_d;
      ostart_q <= ostart_d;
      oend_q   <= oend_d;
      ofirst_q <= ofirst_d;
      ocount_q <= ocount_d;
      total_q  <= total_d;
    end
  end

  // Build the record bundle.
  always_comb begin
    cpos_w     = 64'(cpos);
    ostart_w   = 64'(ostart_q);
    oend_w     = 64'(oend_q);
    s1_start_w = 64'(s1_start);
    last_end_w = 64'(last_end);

    bundle_o.chrom            = chrom_id_i;
    bundle_o.site_pos         = cpos_w[OW-1:0];
    bundle_o.site_idx         = total_q;
    bundle_o.close_site.start = ostart_w[OW-1:0];
    bundle_o.close_site.stop  = oend_w[OW-1:0];
    bundle_o.close_site.first = ofirst_q;
    bundle_o.close_site.count = ocount_q;
    bundle_o.close_last.start = s1_start_w[OW-1:0];
    bundle_o.close_last.stop  = last_end_w[OW-1:0];
    bundle_o.close_last.first = s1_first;
    bundle_o.close_last.count = s1_count;

    mask_o                       = '0;
    mask_o[cpg_pkg::SLOT_SITE]   = is_site;
    mask_o[cpg_pkg::SLOT_CLOSE]  = close_site;
    mask_o[cpg_pkg::SLOT_LAST]   = close_last;
  end

endmodule

// ===== rtl/cpg_rec_queue.sv =====
// ----------------------------------------------------------------------------
// CpG record queue
// Two-entry queue of record bundles; the head bundle is sent out one record
// per transfer, in slot order.
// ----------------------------------------------------------------------------
module cpg_rec_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  cpg_pkg::bundle_t              bundle_i,
  input  logic [cpg_pkg::SLOTS-1:0]     mask_i,
  output logic                          full_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          record_kind_o,
  output logic [cpg_pkg::CHROM_W-1:0]   out_chrom_o,
  output logic [cpg_pkg::OUT_W-1:0]     site_or_start_o,
  output logic [cpg_pkg::OUT_W-1:0]     interval_end_o,
  output logic [cpg_pkg::OUT_W-1:0]     first_site_o,
  output logic [cpg_pkg::OUT_W-1:0]     site_count_o,
  output logic                          last_of_run_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned OW    = cpg_pkg::OUT_W;

  cpg_pkg::bundle_t              ent_q [DEPTH];
  logic [cpg_pkg::SLOTS-1:0]     msk_q [DEPTH];
  logic                          wr_ptr_q, rd_ptr_q;
  logic [1:0]                    cnt_q;

  cpg_pkg::bundle_t              head;
  logic [cpg_pkg::SLOTS-1:0]     head_msk, head_msk_next;
  logic                          xfer, pop;

  // Head record selection.
  always_comb begin
    head          = ent_q[rd_ptr_q];
    head_msk      = msk_q[rd_ptr_q];
    head_msk_next = head_msk & (head_msk - cpg_pkg::SLOTS'(1));
    full_o        = (cnt_q == 2'(DEPTH));
    out_valid_o   = (cnt_q != 2'd0);
    xfer          = out_valid_o && !out_stall_i;
    pop           = xfer && (head_msk_next == '0);
    last_of_run_o = (head_msk_next == '0);
    out_chrom_o   = head.chrom;

    if (head_msk[cpg_pkg::SLOT_SITE]) begin
      record_kind_o   = cpg_pkg::REC_SITE;
      site_or_start_o = head.site_pos;
      interval_end_o  = '0;
      first_site_o    = head.site_idx;
      site_count_o    = OW'(1);
    end else if (head_msk[cpg_pkg::SLOT_CLOSE]) begin
      record_kind_o   = cpg_pkg::REC_IVL;
      site_or_start_o = head.close_site.start;
      interval_end_o  = head.close_site.stop;
      first_site_o    = head.close_site.first;
      site_count_o    = head.close_site.count;
    end else begin
      record_kind_o   = cpg_pkg::REC_IVL;
      site_or_start_o = head.close_last.start;
      interval_end_o  = head.close_last.stop;
      first_site_o    = head.close_last.first;
      site_count_o    = head.close_last.count;
    end
  end

  // Control: pointers, fill count and remaining-record masks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      msk_q[0] <= '0;
      msk_q[1] <= '0;
    end else begin
      if (push_i) begin
        msk_q[wr_ptr_q] <= mask_i;
        wr_ptr_q        <= ~wr_ptr_q;
      end
      if (xfer) begin
        msk_q[rd_ptr_q] <= head_msk_next;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  // Bundle payload storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= bundle_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(DEPTH))
    else $error("record queue fill count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("bundle pushed into a full record queue");

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_msk != '0))
    else $error("valid head bundle holds no record");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1 && pop && !push_i) |=> !out_valid_o)
    else $error("record queue still valid after its last bundle left");
`endif

endmodule

// ===== rtl/cpg_site_window_merger.sv =====
// ----------------------------------------------------------------------------
// CpG site window merger
// Streams sequence characters, reports CpG sites and emits merged windows.
// ----------------------------------------------------------------------------
// One character is taken per cycle while in_stall_o is low. Each character is
// handled by the site scanner, which writes the records it causes (none, or up
// to three: site record, interval closed by the site, interval closed by the
// sequence end) as one bundle into a two-entry queue. The output sends one
// record per transfer, so a character that causes n records holds the output
// for n transfers; input keeps flowing at one character per cycle as long as on
// average no more than one record per character is produced and the output
// is not stalled. in_stall_o rises only when both queue entries are taken.
// kmer_len is written through cfg_we_i/cfg_wdata_i and resets to 25.
module cpg_site_window_merger #(
  parameter int unsigned PosBits = cpg_pkg::POS_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpg_pkg::KMER_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cpg_pkg::CHAR_W-1:0]    seq_char_i,
  input  logic [cpg_pkg::CHROM_W-1:0]   chrom_id_i,
  input  logic                          last_char_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          record_kind_o,
  output logic [cpg_pkg::CHROM_W-1:0]   out_chrom_o,
  output logic [cpg_pkg::OUT_W-1:0]     site_or_start_o,
  output logic [cpg_pkg::OUT_W-1:0]     interval_end_o,
  output logic [cpg_pkg::OUT_W-1:0]     first_site_o,
  output logic [cpg_pkg::OUT_W-1:0]     site_count_o,
  output logic                          last_of_run_o
);

  logic [cpg_pkg::KMER_W-1:0] kmer_len_q;
  logic                       accept, full;
  cpg_pkg::bundle_t           bundle;
  logic [cpg_pkg::SLOTS-1:0]  mask;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q <= cpg_pkg::KMER_RESET;
    end else if (cfg_we_i) begin
      kmer_len_q <= cfg_wdata_i;
    end
  end

  // Input transfer.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  cpg_site_scan #(
    .PosBits (PosBits)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kmer_len_i  (kmer_len_q),
    .accept_i    (accept),
    .seq_char_i  (seq_char_i),
    .chrom_id_i  (chrom_id_i),
    .last_char_i (last_char_i),
    .bundle_o    (bundle),
    .mask_o      (mask)
  );

  cpg_rec_queue u_queue (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (accept && (mask != '0)),
    .bundle_i        (bundle),
    .mask_i          (mask),
    .full_o          (full),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .record_kind_o   (record_kind_o),
    .out_chrom_o     (out_chrom_o),
    .site_or_start_o (site_or_start_o),
    .interval_end_o  (interval_end_o),
    .first_site_o    (first_site_o),
    .site_count_o    (site_count_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// ===== sim/cpg_site_window_checker.sv =====
// ----------------------------------------------------------------------------
// CpG site window merger checker
// Watches the configuration port and both channels of the merger, predicts
// the site and interval records for every accepted character, and compares
// each record that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module cpg_site_window_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpg_pkg::KMER_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [cpg_pkg::CHAR_W-1:0]    seq_char_i,
  input  logic [cpg_pkg::CHROM_W-1:0]   chrom_id_i,
  input  logic                          last_char_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          record_kind_i,
  input  logic [cpg_pkg::CHROM_W-1:0]   out_chrom_i,
  input  logic [cpg_pkg::OUT_W-1:0]     site_or_start_i,
  input  logic [cpg_pkg::OUT_W-1:0]     interval_end_i,
  input  logic [cpg_pkg::OUT_W-1:0]     first_site_i,
  input  logic [cpg_pkg::OUT_W-1:0]     site_count_i,
  input  logic                          last_of_run_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int unsigned POS_W = cpg_pkg::POS_BITS_DEF;
  localparam int unsigned OW    = cpg_pkg::OUT_W;
  localparam int unsigned CW    = cpg_pkg::CHROM_W;

  // One record as it should appear on the output channel.
  typedef struct {
    logic          kind;
    logic [CW-1:0] chrom;
    logic [OW-1:0] pos_or_start;
    logic [OW-1:0] stop;
    logic [OW-1:0] first_idx;
    logic [OW-1:0] count;
    logic          last;
  } rec_t;

  // Scanner state as the block should hold it.
  logic [cpg_pkg::KMER_W-1:0] kmer_len_q;
  logic                       prev_c_q;
  logic [POS_W-1:0]           char_pos_q;
  logic                       open_q;
  logic [POS_W:0]             open_start_q;
  logic [POS_W:0]             open_end_q;
  logic [OW-1:0]              open_first_q;
  logic [OW-1:0]              open_count_q;
  logic [OW-1:0]              total_sites_q;

  rec_t expected_records[$];
  rec_t want;
  int   errors;

  function automatic rec_t make_rec(input logic kind, input logic [CW-1:0] chrom,
                                    input logic [OW-1:0] a, input logic [OW-1:0] e,
                                    input logic [OW-1:0] f, input logic [OW-1:0] c);
    rec_t r;
    r.kind         = kind;
    r.chrom        = chrom;
    r.pos_or_start = a;
    r.stop         = e;
    r.first_idx    = f;
    r.count        = c;
    r.last         = 1'b0;
    return r;
  endfunction

  // Advance the scanner by one character and queue the records it causes.
  task automatic scan_char(input logic [cpg_pkg::CHAR_W-1:0] ch, input logic [CW-1:0] chrom,
                           input logic is_last);
    rec_t             recs[$];
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] cpos;
    logic [POS_W:0]   kmer;
    logic [POS_W:0]   site_end;
    logic [POS_W:0]   win_start;
    logic [POS_W:0]   win_end;
    logic [POS_W:0]   seq_len;
    logic [POS_W:0]   clamped;
    pos  = char_pos_q;
    kmer = (POS_W + 1)'(kmer_len_q);
    if (prev_c_q && ch == cpg_pkg::CHAR_G) begin
      cpos      = pos - POS_W'(1);
      site_end  = {1'b0, cpos} + (POS_W + 1)'(2);
      win_start = (site_end >= kmer) ? site_end - kmer : '0;
      win_end   = {1'b0, cpos} + kmer;
      recs.push_back(make_rec(cpg_pkg::REC_SITE, chrom, cpos[OW-1:0], '0, total_sites_q,
                              OW'(1)));
      if (open_q && open_end_q >= site_end) begin
        // The site still reaches into the open interval, so it joins it.
        open_end_q   = win_end;
        open_count_q = open_count_q + OW'(1);
      end else begin
        if (open_q) begin
          recs.push_back(make_rec(cpg_pkg::REC_IVL, chrom, open_start_q[OW-1:0],
                                  open_end_q[OW-1:0], open_first_q, open_count_q));
        end
        open_q       = 1'b1;
        open_start_q = win_start;
        open_end_q   = win_end;
        open_first_q = total_sites_q;
        open_count_q = OW'(1);
      end
      total_sites_q = total_sites_q + OW'(1);
    end
    if (is_last) begin
      // The sequence end closes the interval, clamped to the sequence length.
      if (open_q) begin
        seq_len = {1'b0, pos} + (POS_W + 1)'(1);
        clamped = (open_end_q > seq_len) ? seq_len : open_end_q;
        recs.push_back(make_rec(cpg_pkg::REC_IVL, chrom, open_start_q[OW-1:0],
                                clamped[OW-1:0], open_first_q, open_count_q));
        open_q = 1'b0;
      end
      char_pos_q = '0;
      prev_c_q   = 1'b0;
    end else begin
      char_pos_q = pos + POS_W'(1);
      prev_c_q   = (ch == cpg_pkg::CHAR_C);
    end
    if (recs.size() > 0) begin
      recs[recs.size()-1].last = 1'b1;
    end
    foreach (recs[i]) begin
      expected_records.push_back(recs[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [OW-1:0] exp_val,
                             input logic [OW-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // Predict on every input transfer, then compare every output transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q    = cpg_pkg::KMER_RESET;
      prev_c_q      = 1'b0;
      char_pos_q    = '0;
      open_q        = 1'b0;
      open_start_q  = '0;
      open_end_q    = '0;
      open_first_q  = '0;
      open_count_q  = '0;
      total_sites_q = '0;
      errors        = 0;
      expected_records.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        kmer_len_q = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        scan_char(seq_char_i, chrom_id_i, last_char_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record, expected none, got kind %0d start %0d end %0d",
                   $time, record_kind_i, site_or_start_i, interval_end_i);
          errors++;
        end else begin
          want = expected_records.pop_front();
          check_field("record_kind", OW'(want.kind), OW'(record_kind_i));
          check_field("out_chrom", OW'(want.chrom), OW'(out_chrom_i));
          check_field("site_or_start", want.pos_or_start, site_or_start_i);
          check_field("interval_end", want.stop, interval_end_i);
          check_field("first_site", want.first_idx, first_site_i);
          check_field("site_count", want.count, site_count_i);
          check_field("last_of_run", OW'(want.last), OW'(last_of_run_i));
        end
      end
      fail_count_o <= errors;
      pending_o    <= expected_records.size();
    end
  end

endmodule

// ===== sim/tb_cpg_site_window_merger.sv =====
// ----------------------------------------------------------------------------
// CpG site window merger testbench
// Streams directed and random character sequences through the merger under
// several k-mer lengths, with random gaps and output stalls, and reports the
// verdict from the failure and pending record counts of the checker.
// ----------------------------------------------------------------------------
module tb_cpg_site_window_merger;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned CHW         = cpg_pkg::CHAR_W;
  localparam int unsigned CRW         = cpg_pkg::CHROM_W;
  localparam int unsigned KW          = cpg_pkg::KMER_W;
  localparam int unsigned OW          = cpg_pkg::OUT_W;

  // Non-matching characters used by the stimulus.
  localparam logic [CHW-1:0] CHAR_A    = 8'd65;
  localparam logic [CHW-1:0] CHAR_T    = 8'd84;
  localparam logic [CHW-1:0] CHAR_LC_C = 8'd99;
  localparam logic [CHW-1:0] CHAR_LC_G = 8'd103;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            cfg_we_i     = 1'b0;
  logic [KW-1:0]   cfg_wdata_i  = '0;
  logic            in_valid_i   = 1'b0;
  logic            in_stall_o;
  logic [CHW-1:0]  seq_char_i   = '0;
  logic [CRW-1:0]  chrom_id_i   = '0;
  logic            last_char_i  = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i  = 1'b0;
  logic            record_kind_o;
  logic [CRW-1:0]  out_chrom_o;
  logic [OW-1:0]   site_or_start_o;
  logic [OW-1:0]   interval_end_o;
  logic [OW-1:0]   first_site_o;
  logic [OW-1:0]   site_count_o;
  logic            last_of_run_o;

  int          fail_count;
  int          pending_records;
  logic        steady = 1'b0;
  int unsigned cycles = 0;

  cpg_site_window_merger i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .seq_char_i     (seq_char_i),
    .chrom_id_i     (chrom_id_i),
    .last_char_i    (last_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .record_kind_o  (record_kind_o),
    .out_chrom_o    (out_chrom_o),
    .site_or_start_o(site_or_start_o),
    .interval_end_o (interval_end_o),
    .first_site_o   (first_site_o),
    .site_count_o   (site_count_o),
    .last_of_run_o  (last_of_run_o)
  );

  cpg_site_window_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .seq_char_i     (seq_char_i),
    .chrom_id_i     (chrom_id_i),
    .last_char_i    (last_char_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .record_kind_i  (record_kind_o),
    .out_chrom_i    (out_chrom_o),
    .site_or_start_i(site_or_start_o),
    .interval_end_i (interval_end_o),
    .first_site_i   (first_site_o),
    .site_count_i   (site_count_o),
    .last_of_run_i  (last_of_run_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_records)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The record sink stalls now and then, except during the steady stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !steady && ($urandom_range(0, 99) < 6);
    end
  end

  // Give up if the run hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_cpg_site_window_merger NOT OK");
      $finish;
    end
  end

  // Offer one character and hold it until the transfer happens.
  task automatic send_char(input logic [CHW-1:0] ch, input logic [CRW-1:0] chrom,
                           input logic is_last);
    logic stalled;
    while (!steady && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    seq_char_i  <= ch;
    chrom_id_i  <= chrom;
    last_char_i <= is_last;
    forever begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
  endtask

  // Send a string of characters, optionally marking the last one as the end.
  task automatic send_text(input string text, input logic [CRW-1:0] chrom,
                           input logic ends_seq);
    for (int i = 0; i < text.len(); i++) begin
      send_char(text[i], chrom, ends_seq && (i == text.len() - 1));
    end
  endtask

  // Stop offering input and wait until every predicted record has left.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (pending_records == 0) break;
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write the k-mer length while the block is idle.
  task automatic set_kmer(input logic [KW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly C and G so that sites cluster, with other bytes mixed in.
  task automatic run_random(input int unsigned n_items);
    logic [CHW-1:0] ch;
    logic [CRW-1:0] chrom;
    logic           is_last;
    int unsigned    r;
    chrom = CRW'($urandom_range(0, 255));
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        ch = cpg_pkg::CHAR_C;
      end else if (r < 70) begin
        ch = cpg_pkg::CHAR_G;
      end else if (r < 78) begin
        ch = CHAR_A;
      end else if (r < 84) begin
        ch = CHAR_T;
      end else if (r < 90) begin
        ch = r[0] ? CHAR_LC_C : CHAR_LC_G;
      end else begin
        ch = CHW'($urandom_range(0, 255));
      end
      is_last = ($urandom_range(0, 11) == 0) || (i == n_items - 1);
      // A new sequence number now and then without a sequence end.
      if ($urandom_range(0, 19) == 0) chrom = CRW'($urandom_range(0, 255));
      send_char(ch, chrom, is_last);
      if (is_last) chrom = chrom + 1'b1;
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length: site at position 0, a merge, and a site on the final character.
    send_text("CGACG", 8'd0, 1'b1);
    // Extreme bytes, lowercase pairs, a sequence number change, a sequence
    // ending on C and a single-character sequence starting with G.
    send_char(8'd0, 8'd255, 1'b0);
    send_char(8'd255, 8'd0, 1'b0);
    send_text("cgCG", 8'd255, 1'b0);
    send_char(cpg_pkg::CHAR_C, 8'd1, 1'b1);
    send_char(cpg_pkg::CHAR_G, 8'd1, 1'b1);
    wait_drained();

    // Two-character window: every site closes the previous interval, and the
    // final character causes three records.
    set_kmer(8'd2);
    send_text("CGCGTTCG", 8'd2, 1'b1);
    wait_drained();

    // Longest window, clamped by the sequence length.
    set_kmer(8'd255);
    send_text("ACG", 8'd3, 1'b1);
    wait_drained();

    // Zero length uses the same formulas.
    set_kmer(8'd0);
    send_text("CGCG", 8'd4, 1'b1);
    wait_drained();

    set_kmer(8'd1);
    run_random(21);
    wait_drained();

    set_kmer(8'd3);
    steady <= 1'b1;
    run_random(21);
    steady <= 1'b0;
    wait_drained();

    set_kmer(KW'($urandom_range(2, 255)));
    run_random(21);
    wait_drained();

    set_kmer(8'd6);
    run_random(21);
    wait_drained();

    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending_records == 0) begin
      $display("tb_cpg_site_window_merger OK");
    end else begin
      $display("tb_cpg_site_window_merger NOT OK");
    end
    $finish;
  end

endmodule
